// File: design/tels_pkg.sv
// shared types and constants for the typed element load/store block
package tels_pkg;

  typedef enum logic [3:0] {
    KIND_I8  = 4'd0,
    KIND_U8  = 4'd1,
    KIND_U8C = 4'd2,
    KIND_I16 = 4'd3,
    KIND_U16 = 4'd4,
    KIND_I32 = 4'd5,
    KIND_U32 = 4'd6,
    KIND_F32 = 4'd7,
    KIND_F64 = 4'd8
  } elem_kind_t;

  localparam logic [1:0] REG_KIND     = 2'd0;
  localparam logic [1:0] REG_BASE     = 2'd1;
  localparam logic [1:0] REG_ELEMENTS = 2'd2;
  localparam logic [1:0] REG_DETACHED = 2'd3;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [7:0] CLAMP_MAX = 8'd255;

  // payload of one input transfer
  typedef struct packed {
    logic        op;
    logic [11:0] elem_index;
    logic [63:0] write_value;
  } in_item_t;

  // payload of one result transfer
  typedef struct packed {
    logic        in_range;
    logic [63:0] read_value;
  } out_item_t;

  // element size as log2 of bytes
  function automatic logic [1:0] size_log2(input logic [3:0] kind);
    logic [1:0] r;
    r = 2'd0;
    unique case (kind)
      KIND_I16, KIND_U16:           r = 2'd1;
      KIND_I32, KIND_U32, KIND_F32: r = 2'd2;
      KIND_F64:                     r = 2'd3;
      default:                      r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/tels_stream_if.sv
// valid/ready stream channel carrying a packed payload
interface tels_stream_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/typed_element_load_store.sv
// Typed element load/store: a little-endian byte store of STORE_BYTES bytes
// held in one 64-bit wide synchronous RAM, viewed as an array of one of nine
// element kinds. Each transfer takes one item at a time through a fixed
// sequence: a clearing pass over every RAM word runs after reset before
// the first item is taken. A read steps through address, RAM read, convert
// and result; a write steps through address, RAM read, convert, merge and
// write back, and result (read-modify-write of the RAM word). Accesses
// that are detached, out of range, misaligned or past the store go straight
// to the result with in_range 0; aligned elements never span two words.
module typed_element_load_store #(
  parameter int STORE_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  tels_stream_if.sink   in_ch,
  tels_stream_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [tels_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tels_pkg::CfgDataW-1:0] cfg_data
);
  localparam int Words = (STORE_BYTES + 7) / 8;
  localparam int WaW   = (Words > 1) ? $clog2(Words) : 1;
  // holds the base plus the largest index scaled by eight bytes
  localparam int AddrW = 16;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_CONV, ST_MERGE, ST_OUT
  } state_t;

  state_t         state_r;
  logic [3:0]     kind_r;
  logic [11:0]    base_r;
  logic [12:0]    elems_r;
  logic           det_r;
  logic [WaW:0]   clr_r;
  logic           op_r;
  logic [63:0]    wv_r;
  logic [WaW-1:0] wa_r;
  logic [2:0]     boff_r;
  logic           ok_r;
  logic [63:0]    word_r;
  tels_pkg::out_item_t res_r;

  tels_pkg::in_item_t in_item;
  assign in_item = tels_pkg::in_item_t'(in_ch.data);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= '0;
      base_r  <= '0;
      elems_r <= '0;
      det_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tels_pkg::REG_KIND:     kind_r  <= cfg_data[3:0];
        tels_pkg::REG_BASE:     base_r  <= cfg_data[11:0];
        tels_pkg::REG_ELEMENTS: elems_r <= cfg_data;
        tels_pkg::REG_DETACHED: det_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // access check and byte address
  logic [1:0]       sl;
  logic [AddrW-1:0] addr;
  logic             acc_ok;
  logic [3:0]       amask;
  always_comb begin
    sl     = tels_pkg::size_log2(kind_r);
    amask  = 4'((4'd1 << sl) - 4'd1);
    addr   = AddrW'(base_r) + (AddrW'(in_item.elem_index) << sl);
    acc_ok = !det_r && kind_r <= tels_pkg::KIND_F64 &&
             {1'b0, in_item.elem_index} < elems_r &&
             (base_r[3:0] & amask) == 4'd0 &&
             ({1'b0, addr} + (AddrW + 1)'(4'd1 << sl)) <= (AddrW + 1)'(STORE_BYTES);
  end

  // storage
  logic           ram_we;
  logic [WaW-1:0] ram_wa, ram_ra;
  logic [63:0]    ram_wd, ram_rd;
  tels_ram #(.WIDTH(64), .DEPTH(Words)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  // extract element from word, and conversion
  logic [63:0] elem_rd, elem_wr, dbl_rd;
  logic [5:0]  bsh;
  assign bsh     = {boff_r, 3'd0};
  assign elem_rd = ram_rd >> bsh;
  tels_conv u_conv (
    .clk(clk), .kind(kind_r), .dbl_in(wv_r), .elem_out(elem_wr),
    .elem_in(elem_rd), .dbl_out(dbl_rd)
  );

  // merge converted element into word
  logic [63:0] emask, merged;
  always_comb begin
    unique case (tels_pkg::size_log2(kind_r))
      2'd0:    emask = 64'hFF;
      2'd1:    emask = 64'hFFFF;
      2'd2:    emask = 64'hFFFF_FFFF;
      default: emask = '1;
    endcase
    merged = (word_r & ~(emask << bsh)) | ((elem_wr & emask) << bsh);
  end

  always_comb begin
    ram_we = (state_r == ST_CLEAR) || (state_r == ST_MERGE);
    ram_wa = (state_r == ST_CLEAR) ? clr_r[WaW-1:0] : wa_r;
    ram_wd = (state_r == ST_CLEAR) ? 64'd0 : merged;
    ram_ra = WaW'(addr >> 3);
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.data  = res_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (WaW + 1)'(Words - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: if (in_ch.valid) begin
          op_r   <= in_item.op;
          wv_r   <= in_item.write_value;
          wa_r   <= WaW'(addr >> 3);
          boff_r <= addr[2:0];
          ok_r   <= acc_ok;
          if (acc_ok) state_r <= ST_READ;
          else begin
            res_r   <= '0;
            state_r <= ST_OUT;
          end
        end
        ST_READ: begin
          word_r  <= ram_rd;
          state_r <= ST_CONV;
        end
        ST_CONV: begin
          if (op_r == tels_pkg::OP_WRITE) state_r <= ST_MERGE;
          else begin
            res_r   <= '{in_range: 1'b1, read_value: dbl_rd};
            state_r <= ST_OUT;
          end
        end
        ST_MERGE: begin
          res_r   <= '{in_range: 1'b1, read_value: 64'd0};
          state_r <= ST_OUT;
        end
        ST_OUT: if (out_ch.ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a write reaches memory only for a checked write access
  a_wr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MERGE |-> ok_r && op_r == tels_pkg::OP_WRITE)
    else $error("write back without valid write");
  // a rejected access reports out of range
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && in_ch.valid && !acc_ok |=> state_r == ST_OUT && !res_r.in_range)
    else $error("rejected access not reported");
  // no input taken while a result waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input accepted with result pending");
endmodule

// File: design/tels_ram.sv
// generic single-port-write, single-port-read ram with registered read
module tels_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

// File: design/tels_conv.sv
// double to element and element to double conversions, one register stage
module tels_conv (
  input  logic        clk,
  input  logic [3:0]  kind,
  input  logic [63:0] dbl_in,
  output logic [63:0] elem_out,
  input  logic [63:0] elem_in,
  output logic [63:0] dbl_out
);
  logic [63:0] elem_r, dbl_r;

  assign elem_out = elem_r;
  assign dbl_out  = dbl_r;

  // write side: double fields
  logic        ws;
  logic [10:0] wex;
  logic [51:0] wfr;
  logic [52:0] wman;
  logic [63:0] int_mag, int_val;
  logic [63:0] sh_full;
  logic [7:0]  clamp_v;
  logic [31:0] f32_v;
  logic [11:0] cl_s;
  logic [63:0] cl_q, cl_rem, cl_half;
  logic [63:0] f_q, f_rem, f_half;
  logic [6:0]  f_s;
  logic [31:0] f_norm;
  logic [63:0] r29;

  // double to integer modulo 2^64, clamped byte and float32
  always_comb begin
    ws   = dbl_in[63];
    wex  = dbl_in[62:52];
    wfr  = dbl_in[51:0];
    wman = {1'b1, wfr};
    int_mag = '0;
    sh_full = '0;
    if (wex != 11'h7FF && wex >= 11'd1023) begin
      if (wex >= 11'd1075) begin
        sh_full = (wex - 11'd1075 >= 11'd64) ? 64'd0 :
                  ({11'd0, wman} << (wex - 11'd1075));
      end else begin
        sh_full = {11'd0, wman} >> (11'd1075 - wex);
      end
      int_mag = sh_full;
    end
    int_val = ws ? (64'd0 - int_mag) : int_mag;

    // clamped byte
    cl_s    = 12'd1075 - {1'b0, wex};
    cl_q    = '0;
    cl_rem  = '0;
    cl_half = '0;
    clamp_v = 8'd0;
    if (wex == 11'h7FF && wfr != '0) begin
      clamp_v = 8'd0;
    end else if (ws) begin
      clamp_v = 8'd0;
    end else if (wex >= 11'd1031) begin
      clamp_v = tels_pkg::CLAMP_MAX;
    end else if (wex < 11'd1022) begin
      clamp_v = 8'd0;
    end else begin
      cl_q    = {11'd0, wman} >> cl_s[5:0];
      cl_rem  = {11'd0, wman} & ((64'd1 << cl_s[5:0]) - 64'd1);
      cl_half = 64'd1 << (cl_s[5:0] - 6'd1);
      if (cl_rem > cl_half || (cl_rem == cl_half && cl_q[0])) begin
        cl_q = cl_q + 64'd1;
      end
      clamp_v = (cl_q > 64'd255) ? tels_pkg::CLAMP_MAX : cl_q[7:0];
    end

    // float32 rounding
    r29 = {11'd0, wman} >> 29;
    if ((wman[28:0] > 29'h1000_0000) ||
        (wman[28:0] == 29'h1000_0000 && r29[0])) begin
      r29 = r29 + 64'd1;
    end
    f_norm = ({21'd0, wex} - 32'd896) << 23;
    f_norm = f_norm + (r29[31:0] - 32'h0080_0000);
    f_s    = 7'd29 + 7'(11'd897 - wex);
    f_q    = '0;
    f_rem  = '0;
    f_half = '0;
    if (wex == 11'h7FF) begin
      f32_v = (wfr == '0) ? {ws, 31'h7F80_0000} :
              {ws, 31'h7FC0_0000 | {8'd0, wfr[51:29]}};
    end else if (wex == 11'd0) begin
      f32_v = {ws, 31'd0};
    end else if (wex > 11'd1150) begin
      f32_v = {ws, 31'h7F80_0000};
    end else if (wex >= 11'd897) begin
      f32_v = {ws, 31'd0} + f_norm;
    end else if (wex < 11'd863) begin
      f32_v = {ws, 31'd0};
    end else begin
      f_q    = {11'd0, wman} >> f_s[5:0];
      f_rem  = {11'd0, wman} & ((64'd1 << f_s[5:0]) - 64'd1);
      f_half = 64'd1 << (f_s[5:0] - 6'd1);
      if (f_rem > f_half || (f_rem == f_half && f_q[0])) begin
        f_q = f_q + 64'd1;
      end
      f32_v = {ws, 31'd0} | f_q[31:0];
    end
  end

  // read side
  logic        rneg;
  logic [32:0] rmag;
  logic [5:0]  rp;
  logic [63:0] int_dbl;
  logic [63:0] f32_dbl;
  logic [31:0] rf;
  logic [4:0]  fp;
  logic [22:0] ffr;
  logic [63:0] ffr_sh;

  // widen element to double
  always_comb begin
    rneg = 1'b0;
    rmag = {1'b0, elem_in[31:0]};
    unique case (kind)
      tels_pkg::KIND_I8: begin
        rneg = elem_in[7];
        rmag = rneg ? 33'(9'h100 - {1'b0, elem_in[7:0]}) : {25'd0, elem_in[7:0]};
      end
      tels_pkg::KIND_U8, tels_pkg::KIND_U8C: begin
        rneg = 1'b0;
        rmag = {25'd0, elem_in[7:0]};
      end
      tels_pkg::KIND_I16: begin
        rneg = elem_in[15];
        rmag = rneg ? 33'(17'h10000 - {1'b0, elem_in[15:0]}) : {17'd0, elem_in[15:0]};
      end
      tels_pkg::KIND_U16: begin
        rneg = 1'b0;
        rmag = {17'd0, elem_in[15:0]};
      end
      tels_pkg::KIND_I32: begin
        rneg = elem_in[31];
        rmag = rneg ? (33'h1_0000_0000 - {1'b0, elem_in[31:0]}) : {1'b0, elem_in[31:0]};
      end
      default: begin
        rneg = 1'b0;
        rmag = {1'b0, elem_in[31:0]};
      end
    endcase
    rp = '0;
    for (int i = 0; i < 33; i++) begin
      if (rmag[i]) rp = 6'(i);
    end
    int_dbl = (rmag == '0) ? 64'd0 :
              {rneg, 11'(11'd1023 + {5'd0, rp}),
               52'(({31'd0, rmag} << (6'd52 - rp)))};

    rf  = elem_in[31:0];
    ffr = rf[22:0];
    fp  = '0;
    for (int i = 0; i < 23; i++) begin
      if (ffr[i]) fp = 5'(i);
    end
    ffr_sh = {41'd0, ffr} << (6'd52 - {1'b0, fp});
    if (rf[30:23] == 8'hFF) begin
      f32_dbl = {rf[31], 11'h7FF, ffr, 29'd0};
    end else if (rf[30:23] == 8'd0) begin
      f32_dbl = (ffr == '0) ? {rf[31], 63'd0} :
                {rf[31], 11'(11'd874 + {6'd0, fp}), ffr_sh[51:0]};
    end else begin
      f32_dbl = {rf[31], 11'({3'd0, rf[30:23]} + 11'd896), ffr, 29'd0};
    end
  end

  // register both directions
  always_ff @(posedge clk) begin
    unique case (kind)
      tels_pkg::KIND_U8C: elem_r <= {56'd0, clamp_v};
      tels_pkg::KIND_F32: elem_r <= {32'd0, f32_v};
      tels_pkg::KIND_F64: elem_r <= dbl_in;
      default:            elem_r <= int_val;
    endcase
    unique case (kind)
      tels_pkg::KIND_F32: dbl_r <= f32_dbl;
      tels_pkg::KIND_F64: dbl_r <= elem_in;
      default:            dbl_r <= int_dbl;
    endcase
  end
endmodule
